// ===== sv/btpc_pkg.sv =====
// Shared constants and payload types for the barometric compensation block.
package btpc_pkg;

   // Configuration register indexes
   localparam logic [2:0] CSR_OSS  = 3'd0;
   localparam logic [2:0] CSR_AC12 = 3'd1;
   localparam logic [2:0] CSR_AC34 = 3'd2;
   localparam logic [2:0] CSR_AC56 = 3'd3;
   localparam logic [2:0] CSR_B12  = 3'd4;
   localparam logic [2:0] CSR_MCMD = 3'd5;

   // Divider geometries: temperature and pressure
   localparam int T_NUM_W = 27;
   localparam int T_DEN_W = 18;
   localparam int P_NUM_W = 32;
   localparam int P_DEN_W = 17;

   // Compensation constants
   localparam logic signed [28:0] B6_OFFSET  = 29'sd4000;
   localparam logic [15:0]        PRES_SCALE = 16'd50000;
   localparam logic [11:0]        PRES_C1    = 12'd3038;
   localparam logic [12:0]        PRES_C2    = 13'd7357;
   localparam logic signed [47:0] PRES_C3    = 48'sd3791;
   localparam logic [31:0]        X3_OFFSET  = 32'd32768;
   localparam logic signed [47:0] PRES_MAX   = 48'sd262143;
   localparam logic signed [25:0] TEMP_MAX   = 26'sd32767;
   localparam logic signed [25:0] TEMP_MIN   = -26'sd32768;

   // Side data carried through the temperature divider
   typedef struct packed {
      logic [18:0]        up;
      logic signed [18:0] x1;
      logic               qneg;
      logic               terr;
   } tpay_type;

   // Side data carried between the two dividers
   typedef struct packed {
      logic [18:0]        up;
      logic signed [28:0] b5;
      logic               err;
   } side_type;

   // Side data carried through the pressure divider
   typedef struct packed {
      logic               hi;
      logic               err;
      logic signed [28:0] b5;
   } ppay_type;

   // Side data carried after the pressure divider
   typedef struct packed {
      logic               err;
      logic signed [28:0] b5;
   } post_type;

endpackage

// ===== sv/baro_temp_pressure_compensation.sv =====
// Barometric temperature and pressure compensation pipeline, top level.
// Takes raw temperature/pressure pairs and returns temperature in tenths of a
// degree and pressure in pascals, with calc_error set (and both values zero)
// when a divisor is zero. Throughput is one transaction per cycle unless
// stalled. There are 21 arithmetic stages plus a 27-stage temperature divider
// and a 32-stage pressure divider, each retiring one quotient bit per stage.
// The whole pipeline advances together whenever the result register is empty
// or being taken, so req_tready drops only while a result is stalled.
// Calibration registers are read live and must be written only while idle.
module baro_temp_pressure_compensation
   import btpc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // req_tdata: [15:0] raw_temperature, [39:16] raw_pressure_bytes
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,
   // rsp_tdata: [15:0] temperature_tenths, [33:16] pressure_pa, [39:34] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,
   // rsp_tuser: [0] calc_error
   output logic [0:0]  rsp_tuser,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   // Configuration registers
   logic [1:0]  oss_ff;
   logic [31:0] ac12_ff, ac34_ff, ac56_ff, b12_ff, mcmd_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         oss_ff  <= '0;
         ac12_ff <= '0;
         ac34_ff <= '0;
         ac56_ff <= '0;
         b12_ff  <= '0;
         mcmd_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_OSS:  oss_ff  <= csr_data[1:0];
            CSR_AC12: ac12_ff <= csr_data;
            CSR_AC34: ac34_ff <= csr_data;
            CSR_AC56: ac56_ff <= csr_data;
            CSR_B12:  b12_ff  <= csr_data;
            CSR_MCMD: mcmd_ff <= csr_data;
            default:  ;
         endcase
      end
   end

   // Unpack coefficients
   logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
   logic [15:0]        ac4, ac5, ac6;

   assign ac1 = $signed(ac12_ff[31:16]);
   assign ac2 = $signed(ac12_ff[15:0]);
   assign ac3 = $signed(ac34_ff[31:16]);
   assign ac4 = ac34_ff[15:0];
   assign ac5 = ac56_ff[31:16];
   assign ac6 = ac56_ff[15:0];
   assign b1  = $signed(b12_ff[31:16]);
   assign b2  = $signed(b12_ff[15:0]);
   assign mc  = $signed(mcmd_ff[31:16]);
   assign md  = $signed(mcmd_ff[15:0]);

   // Global advance: move when the result register is free or being taken
   logic adv;
   logic rsp_valid_ff;

   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;

   // Stage valids
   logic a_v_ff, b_v_ff, c_v_ff, d_v_ff;
   logic e_v_ff, f_v_ff, g_v_ff, h_v_ff, i_v_ff, j_v_ff, k_v_ff, l_v_ff;
   logic m_v_ff, n_v_ff, o_v_ff;
   logic q_v_ff, r_v_ff, s_v_ff, u_v_ff, w_v_ff;
   logic tq_v, pq_v;

   // Stage payloads
   logic signed [16:0] a_diff_ff;
   logic [18:0]        a_up_ff, b_up_ff, c_up_ff;
   logic signed [33:0] b_prod_ff;
   logic signed [18:0] c_x1_ff;
   logic [T_NUM_W-1:0] d_num_ff;
   logic [T_DEN_W-1:0] d_den_ff;
   tpay_type           d_pay_ff;
   logic [T_NUM_W-1:0] tq_quo;
   tpay_type           tq_pay;
   side_type           e_side_ff, f_side_ff, g_side_ff, h_side_ff, i_side_ff;
   side_type           j_side_ff, k_side_ff, l_side_ff, m_side_ff, n_side_ff;
   logic signed [28:0] f_b6_ff;
   logic signed [57:0] g_sqp_ff;
   logic signed [44:0] g_p2_ff, g_p3_ff;
   logic signed [43:0] h_sq_ff;
   logic signed [33:0] h_x2a_ff, i_x2a_ff, j_x2a_ff;
   logic signed [31:0] h_x1c_ff, i_x1c_ff, j_x1c_ff;
   logic signed [59:0] i_m1_ff, i_m2_ff;
   logic signed [48:0] j_x1a_ff;
   logic signed [43:0] j_x2c_ff;
   logic signed [50:0] k_s_ff;
   logic signed [44:0] k_x3p_ff;
   logic [31:0]        l_b3_ff, l_t4_ff, m_d_ff, n_b7_ff;
   logic [16:0]        m_b4_ff, n_b4_ff;
   logic [P_NUM_W-1:0] o_num_ff;
   logic [P_DEN_W-1:0] o_den_ff;
   ppay_type           o_pay_ff;
   logic [P_NUM_W-1:0] pq_quo;
   ppay_type           pq_pay;
   post_type           q_post_ff, r_post_ff, s_post_ff, u_post_ff, w_post_ff;
   logic [32:0]        q_p_ff, r_p_ff, s_p_ff, u_p_ff;
   logic [49:0]        r_psq_ff;
   logic [45:0]        r_pm_ff;
   logic [61:0]        s_x1m_ff;
   logic [29:0]        s_x2n_ff;
   logic signed [47:0] u_sum_ff, w_pf_ff;
   logic signed [15:0] rsp_temp_ff;
   logic [17:0]        rsp_pres_ff;
   logic               rsp_err_ff;

   // Advance valids
   always_ff @(posedge clock) begin
      if (reset) begin
         {a_v_ff, b_v_ff, c_v_ff, d_v_ff} <= '0;
         {e_v_ff, f_v_ff, g_v_ff, h_v_ff, i_v_ff, j_v_ff} <= '0;
         {k_v_ff, l_v_ff, m_v_ff, n_v_ff, o_v_ff} <= '0;
         {q_v_ff, r_v_ff, s_v_ff, u_v_ff, w_v_ff, rsp_valid_ff} <= '0;
      end else if (adv) begin
         a_v_ff <= req_tvalid;
         b_v_ff <= a_v_ff;
         c_v_ff <= b_v_ff;
         d_v_ff <= c_v_ff;
         e_v_ff <= tq_v;
         f_v_ff <= e_v_ff;
         g_v_ff <= f_v_ff;
         h_v_ff <= g_v_ff;
         i_v_ff <= h_v_ff;
         j_v_ff <= i_v_ff;
         k_v_ff <= j_v_ff;
         l_v_ff <= k_v_ff;
         m_v_ff <= l_v_ff;
         n_v_ff <= m_v_ff;
         o_v_ff <= n_v_ff;
         q_v_ff <= pq_v;
         r_v_ff <= q_v_ff;
         s_v_ff <= r_v_ff;
         u_v_ff <= s_v_ff;
         w_v_ff <= u_v_ff;
         rsp_valid_ff <= w_v_ff;
      end
   end

   // Front end: raw pressure alignment and first temperature term
   logic [23:0]        up_full;
   logic signed [33:0] prod_adj;
   logic signed [19:0] tdiv;
   logic [19:0]        tdiv_abs;
   logic [15:0]        mc_mag;

   always_comb begin
      up_full  = req_tdata[39:16] >> (4'd8 - {2'b00, oss_ff});
      prod_adj = b_prod_ff + (b_prod_ff[33] ? 34'sd32767 : 34'sd0);
      tdiv     = c_x1_ff + md;
      tdiv_abs = tdiv[19] ? 20'(-tdiv) : 20'(tdiv);
      mc_mag   = mc[15] ? (~mcmd_ff[31:16] + 16'd1) : mcmd_ff[31:16];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_diff_ff <= $signed({1'b0, req_tdata[15:0]}) - $signed({1'b0, ac6});
         a_up_ff   <= up_full[18:0];
         b_prod_ff <= a_diff_ff * $signed({1'b0, ac5});
         b_up_ff   <= a_up_ff;
         c_x1_ff   <= prod_adj[33:15];
         c_up_ff   <= b_up_ff;
         d_num_ff  <= {mc_mag, 11'b0};
         d_den_ff  <= tdiv_abs[T_DEN_W-1:0];
         d_pay_ff  <= '{up: c_up_ff, x1: c_x1_ff, qneg: mc[15] ^ tdiv[19],
                        terr: (tdiv == 20'sd0)};
      end
   end

   btpc_div #(
      .NUM_W (T_NUM_W),
      .DEN_W (T_DEN_W),
      .PAY_W ($bits(tpay_type))
   ) u_tdiv (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (d_v_ff),
      .in_num    (d_num_ff),
      .in_den    (d_den_ff),
      .in_pay    (d_pay_ff),
      .out_valid (tq_v),
      .out_quo   (tq_quo),
      .out_pay   (tq_pay)
   );

   // Middle: B5, B6, B3, B4 and B7 terms
   logic signed [27:0] tq_s;
   logic signed [44:0] p2_adj, p3_adj, x3_adj;
   logic signed [59:0] m1_adj, m2_adj;
   logic signed [54:0] sh, sh_adj;
   logic [47:0]        b4_prod, b7_prod;

   always_comb begin
      tq_s    = tq_pay.qneg ? -$signed({1'b0, tq_quo}) : $signed({1'b0, tq_quo});
      p2_adj  = g_p2_ff + (g_p2_ff[44] ? 45'sd2047 : 45'sd0);
      p3_adj  = g_p3_ff + (g_p3_ff[44] ? 45'sd8191 : 45'sd0);
      m1_adj  = i_m1_ff + (i_m1_ff[59] ? 60'sd2047 : 60'sd0);
      m2_adj  = i_m2_ff + (i_m2_ff[59] ? 60'sd65535 : 60'sd0);
      sh      = (55'(k_s_ff) <<< oss_ff) + 55'sd2;
      sh_adj  = sh + (sh[54] ? 55'sd3 : 55'sd0);
      x3_adj  = k_x3p_ff + (k_x3p_ff[44] ? 45'sd3 : 45'sd0);
      b4_prod = 48'(ac4) * 48'(l_t4_ff);
      b7_prod = 48'(m_d_ff) * 48'(PRES_SCALE >> oss_ff);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e_side_ff <= '{up: tq_pay.up, b5: tq_pay.x1 + tq_s, err: tq_pay.terr};
         f_b6_ff   <= e_side_ff.b5 - B6_OFFSET;
         f_side_ff <= e_side_ff;
         g_sqp_ff  <= f_b6_ff * f_b6_ff;
         g_p2_ff   <= ac2 * f_b6_ff;
         g_p3_ff   <= ac3 * f_b6_ff;
         g_side_ff <= f_side_ff;
         h_sq_ff   <= g_sqp_ff[55:12];
         h_x2a_ff  <= p2_adj[44:11];
         h_x1c_ff  <= p3_adj[44:13];
         h_side_ff <= g_side_ff;
         i_m1_ff   <= b2 * h_sq_ff;
         i_m2_ff   <= b1 * h_sq_ff;
         i_x2a_ff  <= h_x2a_ff;
         i_x1c_ff  <= h_x1c_ff;
         i_side_ff <= h_side_ff;
         j_x1a_ff  <= m1_adj[59:11];
         j_x2c_ff  <= m2_adj[59:16];
         j_x2a_ff  <= i_x2a_ff;
         j_x1c_ff  <= i_x1c_ff;
         j_side_ff <= i_side_ff;
         k_s_ff    <= ac1 * 51'sd4 + j_x1a_ff + j_x2a_ff;
         k_x3p_ff  <= j_x1c_ff + j_x2c_ff + 45'sd2;
         k_side_ff <= j_side_ff;
         l_b3_ff   <= sh_adj[33:2];
         l_t4_ff   <= x3_adj[33:2] + X3_OFFSET;
         l_side_ff <= k_side_ff;
         m_d_ff    <= {13'b0, l_side_ff.up} - l_b3_ff;
         m_b4_ff   <= b4_prod[31:15];
         m_side_ff <= l_side_ff;
         n_b7_ff   <= b7_prod[31:0];
         n_b4_ff   <= m_b4_ff;
         n_side_ff <= '{up: m_side_ff.up, b5: m_side_ff.b5,
                        err: m_side_ff.err | (m_b4_ff == 17'd0)};
         o_num_ff  <= n_b7_ff[31] ? n_b7_ff : {n_b7_ff[30:0], 1'b0};
         o_den_ff  <= n_b4_ff;
         o_pay_ff  <= '{hi: n_b7_ff[31], err: n_side_ff.err, b5: n_side_ff.b5};
      end
   end

   btpc_div #(
      .NUM_W (P_NUM_W),
      .DEN_W (P_DEN_W),
      .PAY_W ($bits(ppay_type))
   ) u_pdiv (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (o_v_ff),
      .in_num    (o_num_ff),
      .in_den    (o_den_ff),
      .in_pay    (o_pay_ff),
      .out_valid (pq_v),
      .out_quo   (pq_quo),
      .out_pay   (pq_pay)
   );

   // Back end: pressure correction polynomial
   logic signed [47:0] sum_adj;
   logic signed [43:0] pcorr;

   always_comb begin
      sum_adj = u_sum_ff + (u_sum_ff[47] ? 48'sd15 : 48'sd0);
      pcorr   = sum_adj[47:4];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         q_p_ff    <= pq_pay.hi ? {pq_quo, 1'b0} : {1'b0, pq_quo};
         q_post_ff <= '{err: pq_pay.err, b5: pq_pay.b5};
         r_psq_ff  <= 50'(q_p_ff[32:8]) * 50'(q_p_ff[32:8]);
         r_pm_ff   <= 46'(q_p_ff) * 46'(PRES_C2);
         r_p_ff    <= q_p_ff;
         r_post_ff <= q_post_ff;
         s_x1m_ff  <= 62'(r_psq_ff) * 62'(PRES_C1);
         s_x2n_ff  <= r_pm_ff[45:16];
         s_p_ff    <= r_p_ff;
         s_post_ff <= r_post_ff;
         u_sum_ff  <= $signed({2'b0, s_x1m_ff[61:16]}) - $signed({18'b0, s_x2n_ff})
                      + PRES_C3;
         u_p_ff    <= s_p_ff;
         u_post_ff <= s_post_ff;
         w_pf_ff   <= pcorr + $signed({15'b0, u_p_ff});
         w_post_ff <= u_post_ff;
      end
   end

   // Output: rounding, saturation and error zeroing
   logic signed [29:0] tt, tt_adj;
   logic signed [25:0] t26;
   logic signed [15:0] temp_in;
   logic [17:0]        pres_in;

   always_comb begin
      tt     = w_post_ff.b5 + 30'sd8;
      tt_adj = tt + (tt[29] ? 30'sd15 : 30'sd0);
      t26    = tt_adj[29:4];
      priority if (t26 > TEMP_MAX) begin
         temp_in = TEMP_MAX[15:0];
      end else if (t26 < TEMP_MIN) begin
         temp_in = TEMP_MIN[15:0];
      end else begin
         temp_in = t26[15:0];
      end
      priority if (w_pf_ff[47]) begin
         pres_in = '0;
      end else if (w_pf_ff > PRES_MAX) begin
         pres_in = PRES_MAX[17:0];
      end else begin
         pres_in = w_pf_ff[17:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_err_ff  <= w_post_ff.err;
         rsp_temp_ff <= w_post_ff.err ? 16'sd0 : temp_in;
         rsp_pres_ff <= w_post_ff.err ? 18'd0 : pres_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_pres_ff, rsp_temp_ff};
   assign rsp_tuser  = rsp_err_ff;

   // Error result carries zero values
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[33:0] == 34'd0)
      else $error("error result with nonzero values");

   // A stalled result blocks new transactions
   a_stall_block: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input accepted while result stalled");

   // Reset empties the result register
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

// ===== sv/btpc_div.sv =====
// Pipelined restoring unsigned divider, one quotient bit per stage.
module btpc_div
   import btpc_pkg::*;
#(
   parameter int NUM_W = T_NUM_W,
   parameter int DEN_W = T_DEN_W,
   parameter int PAY_W = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [NUM_W-1:0] in_num,
   input  logic [DEN_W-1:0] in_den,
   input  logic [PAY_W-1:0] in_pay,
   output logic             out_valid,
   output logic [NUM_W-1:0] out_quo,
   output logic [PAY_W-1:0] out_pay
);

   logic             v_ff   [NUM_W];
   logic [DEN_W-1:0] rem_ff [NUM_W];
   logic [NUM_W-1:0] nq_ff  [NUM_W];
   logic [DEN_W-1:0] den_ff [NUM_W];
   logic [PAY_W-1:0] pay_ff [NUM_W];

   for (genvar g = 0; g < NUM_W; g++) begin : g_stage
      logic             pv;
      logic [DEN_W-1:0] prem;
      logic [DEN_W-1:0] pden;
      logic [NUM_W-1:0] pnq;
      logic [PAY_W-1:0] ppay;
      logic [DEN_W:0]   trial;
      logic [DEN_W:0]   diff;
      logic             ge;
      logic [DEN_W-1:0] rem_in;
      logic [NUM_W-1:0] nq_in;

      // Pick up the previous stage or the input port
      if (g == 0) begin : g_first
         assign pv   = in_valid;
         assign prem = '0;
         assign pden = in_den;
         assign pnq  = in_num;
         assign ppay = in_pay;
      end else begin : g_next
         assign pv   = v_ff[g-1];
         assign prem = rem_ff[g-1];
         assign pden = den_ff[g-1];
         assign pnq  = nq_ff[g-1];
         assign ppay = pay_ff[g-1];
      end

      // Shift in the next numerator bit and try a subtract
      always_comb begin
         trial  = {prem, pnq[NUM_W-1]};
         diff   = trial - {1'b0, pden};
         ge     = (trial >= {1'b0, pden});
         rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         nq_in  = {pnq[NUM_W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[g] <= 1'b0;
         end else if (en) begin
            v_ff[g] <= pv;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[g] <= rem_in;
            nq_ff[g]  <= nq_in;
            den_ff[g] <= pden;
            pay_ff[g] <= ppay;
         end
      end
   end

   assign out_valid = v_ff[NUM_W-1];
   assign out_quo   = nq_ff[NUM_W-1];
   assign out_pay   = pay_ff[NUM_W-1];

   // Remainder must end below a nonzero divisor
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      v_ff[NUM_W-1] && (den_ff[NUM_W-1] != '0) |-> rem_ff[NUM_W-1] < den_ff[NUM_W-1])
      else $error("divider remainder not below divisor");

   // A stall holds the final stage
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(out_valid) && $stable(out_quo))
      else $error("divider output moved during stall");

   // Reset empties the final stage
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !out_valid)
      else $error("divider output valid right after reset");

endmodule
